// File: rtl/hla_pkg.sv
// Shared types and constants for the Huber loss accumulator.
package hla_pkg;

  localparam int unsigned SumW     = 48;
  localparam int unsigned CntW     = 17;
  localparam int unsigned LossW    = 31;
  localparam int unsigned DeltaW   = 15;
  localparam int unsigned DivSteps = SumW - 1;
  localparam int unsigned StepW    = $clog2(DivSteps);

  localparam logic [DeltaW-1:0] DeltaRst = 15'd4096;

  typedef struct packed {
    logic signed [15:0] predicted;
    logic signed [15:0] expected;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [LossW-1:0] loss;
    logic [CntW-1:0]  pair_count;
    logic             overflow;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic start;  // capture sum and count into the divider, clear the set
    logic step;   // one restoring division step
    logic load;   // move the quotient into the output register
  } hla_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tail_done;  // last pair of the set has reached the accumulator
    logic out_free;   // output register can take a result this cycle
  } hla_stat_t;

endpackage

// File: rtl/huber_loss_accumulator.sv
// Top level of the Huber loss accumulator: controller plus datapath.
//
//   channel | direction | handshake      | payload
//   in_     | input     | valid / stall  | in_item_t  (predicted, expected, last)
//   out_    | output    | valid / stall  | out_item_t (loss, pair_count, overflow)
//   cfg_    | input     | valid / ready  | delta, 15 bits
//
// One pair per cycle while a set accumulates (three-stage term pipeline).
// A last pair closes the set: the term pipeline drains, then the start step and
// the one-bit-per-cycle restoring divider run, then the result is handed off;
// input stalls from the last request until that hand-off.
// The result sits in an output register; a result still stalled when the next
// set finishes holds that set's hand-off, and the input with it. Synchronous
// active-low reset clears sum, count and flags and sets delta to 1.0.
module huber_loss_accumulator import hla_pkg::*; #(
  parameter int unsigned MAX_COUNT = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DeltaW-1:0] cfg_data
);

  hla_cmd_t  cmd;
  hla_stat_t stat;
  logic      in_acc;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  hla_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_last_acc (in_acc && in_data.last),
    .stat        (stat),
    .cmd         (cmd),
    .in_stall    (in_stall)
  );

  hla_datapath #(
    .MAX_COUNT (MAX_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/hla_datapath.sv
// Datapath: error and Huber term pipeline, accumulator, serial divider, output register.
module hla_datapath import hla_pkg::*; #(
  parameter int unsigned MAX_COUNT = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_acc,
  input  in_item_t          in_data,
  input  logic              cfg_we,
  input  logic [DeltaW-1:0] cfg_data,
  input  hla_cmd_t          cmd,
  output hla_stat_t         stat,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_COUNT);

  logic [DeltaW-1:0] delta_r;
  logic [CntW-1:0]   count_r;
  logic              ovf_r;
  logic [SumW-1:0]   sum_r;

  logic              s1_add_r, s1_last_r;
  logic [16:0]       mul_a_r, mul_b_r;
  logic              s2_add_r, s2_last_r;
  logic [31:0]       term_r;

  logic [CntW-1:0]   div_r;
  logic              ovf_hold_r;
  logic [CntW-1:0]   rem_r;
  logic [SumW-2:0]   quo_r;

  logic              out_valid_r;
  out_item_t         out_r;

  logic signed [16:0] err;
  logic [16:0]        err_abs;
  logic [15:0]        mag;
  logic               quad;
  logic               keep;
  logic [16:0]        lin_b;
  logic [33:0]        prod;
  logic [CntW:0]      trial;
  logic               q_bit;

  always_comb begin
    err     = {in_data.predicted[15], in_data.predicted}
            - {in_data.expected[15], in_data.expected};
    err_abs = err[16] ? 17'(-err) : 17'(err);
    mag     = err_abs[15:0];
    quad    = ({1'b0, mag} <= {2'b00, delta_r});
    lin_b   = {mag, 1'b0} - {2'b00, delta_r};
    keep    = (count_r < MaxCnt);
    prod    = mul_a_r * mul_b_r;
    trial   = {rem_r, quo_r[SumW-2]};
    q_bit   = (trial >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r     <= DeltaRst;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      sum_r       <= '0;
      s1_add_r    <= 1'b0;
      s1_last_r   <= 1'b0;
      s2_add_r    <= 1'b0;
      s2_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        delta_r <= cfg_data;
      end

      s1_add_r  <= in_acc && keep;
      s1_last_r <= in_acc && in_data.last;
      if (in_acc) begin
        if (keep) begin
          count_r <= count_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end

      s2_add_r  <= s1_add_r;
      s2_last_r <= s1_last_r;

      if (cmd.start) begin
        sum_r   <= '0;
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (s2_add_r) begin
        sum_r <= sum_r + {{(SumW-32){1'b0}}, term_r};
      end

      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mul_a_r <= quad ? {1'b0, mag} : {2'b00, delta_r};
      mul_b_r <= quad ? {1'b0, mag} : lin_b;
    end
    term_r <= prod[31:0];

    if (cmd.start) begin
      // floor(sum / (2n)) == floor(floor(sum / 2) / n)
      div_r      <= count_r;
      ovf_hold_r <= ovf_r;
      rem_r      <= '0;
      quo_r      <= sum_r[SumW-1:1];
    end else if (cmd.step) begin
      rem_r <= q_bit ? CntW'(trial - {1'b0, div_r}) : trial[CntW-1:0];
      quo_r <= {quo_r[SumW-3:0], q_bit};
    end

    if (cmd.load) begin
      out_r.loss       <= quo_r[LossW-1:0];
      out_r.pair_count <= div_r;
      out_r.overflow   <= ovf_hold_r;
    end
  end

  assign stat.tail_done = s2_last_r;
  assign stat.out_free  = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

endmodule

// File: rtl/hla_ctrl.sv
// Controller: sequences accumulation, drain, division and result hand-off.
module hla_ctrl import hla_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_last_acc,
  input  hla_stat_t stat,
  output hla_cmd_t  cmd,
  output logic      in_stall
);

  typedef enum logic [2:0] {
    ST_ACC,
    ST_DRAIN,
    ST_START,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t           state_r;
  logic [StepW-1:0] step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        ST_ACC: begin
          if (in_last_acc) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // wait for the last pair to land in the sum
          if (stat.tail_done) begin
            state_r <= ST_START;
          end
        end
        ST_START: begin
          step_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          step_r <= step_r + 1'b1;
          if (step_r == StepW'(DivSteps - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (stat.out_free) begin
            state_r <= ST_ACC;
          end
        end
        default: state_r <= ST_ACC;
      endcase
    end
  end

  assign cmd.start = (state_r == ST_START);
  assign cmd.step  = (state_r == ST_DIV);
  assign cmd.load  = (state_r == ST_FIN) && stat.out_free;
  assign in_stall  = (state_r != ST_ACC);

endmodule

// File: dv/huber_loss_accumulator_tb.sv
// Self-checking testbench for the Huber loss accumulator: random streams of pair sets.
module huber_loss_accumulator_tb import hla_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxCount     = 65536;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned PhaseItems   = 195;

  // Predicts the mean Huber loss of each pair set and matches it against the block.
  class huber_mean_sb;
    logic [DeltaW-1:0] delta_q;
    logic [SumW-1:0]   sum_q;
    logic [CntW-1:0]   cnt_q;
    bit                ovf_q;
    int unsigned       max_count;
    out_item_t         mean_q[$];
    int unsigned       errors;
    int unsigned       pairs_noted;
    int unsigned       pairs_dropped;
    int unsigned       sets_checked;
    int unsigned       delta_writes;

    function new(int unsigned max_count);
      this.max_count = max_count;
      delta_q = DeltaRst;
      sum_q = '0;
      cnt_q = '0;
      ovf_q = 1'b0;
      errors = 0;
      pairs_noted = 0;
      pairs_dropped = 0;
      sets_checked = 0;
      delta_writes = 0;
    endfunction

    function void set_delta(logic [DeltaW-1:0] d);
      delta_q = d;
      delta_writes++;
    endfunction

    function int unsigned waiting();
      return mean_q.size();
    endfunction

    function void note_pair(in_item_t it);
      logic [16:0]     err;
      logic [16:0]     mag;
      logic [SumW-1:0] m48;
      logic [SumW-1:0] d48;
      logic [SumW-1:0] term;
      logic [SumW-1:0] div48;
      logic [SumW-1:0] quo;
      out_item_t       mean_r;
      err = {it.predicted[15], it.predicted} - {it.expected[15], it.expected};
      mag = err[16] ? (~err + 17'd1) : err;
      m48 = SumW'(mag);
      d48 = SumW'(delta_q);
      if (m48 <= d48) begin
        term = m48 * m48;
      end else begin
        term = d48 * ((m48 << 1) - d48);
      end
      pairs_noted++;
      if (cnt_q < max_count) begin
        sum_q = sum_q + term;
        cnt_q = cnt_q + 1'b1;
      end else begin
        // drop: set already full
        ovf_q = 1'b1;
        pairs_dropped++;
      end
      if (it.last) begin
        div48 = {cnt_q, 1'b0};
        quo = sum_q / div48;
        mean_r.loss = quo[LossW-1:0];
        mean_r.pair_count = cnt_q;
        mean_r.overflow = ovf_q;
        mean_q.push_back(mean_r);
        sum_q = '0;
        cnt_q = '0;
        ovf_q = 1'b0;
      end
    endfunction

    function void check_mean(out_item_t got);
      out_item_t want;
      if (mean_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual loss %0d count %0d ovf %0d",
                 $time, got.loss, got.pair_count, got.overflow);
        return;
      end
      want = mean_q.pop_front();
      sets_checked++;
      if (got.loss !== want.loss) begin
        errors++;
        $display("%0t: loss mismatch, expected %0d actual %0d", $time, want.loss, got.loss);
      end
      if (got.pair_count !== want.pair_count) begin
        errors++;
        $display("%0t: pair_count mismatch, expected %0d actual %0d",
                 $time, want.pair_count, got.pair_count);
      end
      if (got.overflow !== want.overflow) begin
        errors++;
        $display("%0t: overflow mismatch, expected %0d actual %0d",
                 $time, want.overflow, got.overflow);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [DeltaW-1:0] cfg_data;

  huber_mean_sb sb;
  int unsigned  burst_left;
  bit           bursty;
  int unsigned  cycles;

  huber_loss_accumulator #(.MAX_COUNT(MaxCount)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: cycle limit of %0d reached", $time, CycleLimit);
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: check accepted results, stall in changing modes.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned run_left;
    bit          run_val;
    mode = 0;
    mode_left = 0;
    run_left = 0;
    run_val = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_mean(out_data);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          if (run_left == 0) begin
            run_val = ~run_val;
            run_left = $urandom_range(1, 20);
          end
          run_left--;
          out_stall <= run_val;
        end
      endcase
    end
  end

  function automatic in_item_t mk_pair(int p, int x, bit l);
    in_item_t it;
    it.predicted = 16'(p);
    it.expected = 16'(x);
    it.last = l;
    return it;
  endfunction

  // Mix of raw values, pairs near the threshold, range corners and small values.
  function automatic in_item_t random_pair();
    int p;
    int x;
    int d;
    int r;
    int corner[5];
    corner[0] = -32768;
    corner[1] = -1;
    corner[2] = 0;
    corner[3] = 1;
    corner[4] = 32767;
    d = int'(sb.delta_q);
    r = $urandom_range(0, 9);
    p = int'($urandom_range(0, 65535)) - 32768;
    if (r < 4) begin
      x = int'($urandom_range(0, 65535)) - 32768;
    end else if (r < 7) begin
      x = p - (int'($urandom_range(0, 2 * d + 4)) - (d + 2));
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
    end else if (r < 8) begin
      p = corner[$urandom_range(0, 4)];
      x = corner[$urandom_range(0, 4)];
    end else begin
      p = int'($urandom_range(0, 255)) - 128;
      x = int'($urandom_range(0, 255)) - 128;
    end
    return mk_pair(p, x, 1'b0);
  endfunction

  task automatic send_pair(in_item_t it);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_pair(it);
    if (bursty) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic run_set(int unsigned len);
    in_item_t it;
    for (int unsigned i = 0; i < len; i++) begin
      it = random_pair();
      it.last = (i == len - 1);
      send_pair(it);
    end
  endtask

  // Hold input until every pending mean is out, then let the divider settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_delta(logic [DeltaW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_delta(d);
  endtask

  initial begin
    logic [DeltaW-1:0] phase_delta[7];
    int unsigned       sent;
    int unsigned       len;
    int unsigned       r;
    sb = new(MaxCount);
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    bursty = 1'b1;
    burst_left = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset threshold of 1.0: zero error, largest errors, threshold boundary.
    send_pair(mk_pair(0, 0, 1'b1));
    send_pair(mk_pair(32767, -32768, 1'b1));
    send_pair(mk_pair(-32768, 32767, 1'b1));
    send_pair(mk_pair(4096, 0, 1'b0));
    send_pair(mk_pair(0, 4097, 1'b0));
    send_pair(mk_pair(-4095, 0, 1'b1));
    drain_results();
    write_delta(15'd32767);
    send_pair(mk_pair(32767, 0, 1'b0));
    send_pair(mk_pair(-1, 32767, 1'b0));
    send_pair(mk_pair(32767, -32768, 1'b1));
    drain_results();
    // Zero threshold: every term vanishes.
    write_delta(15'd0);
    send_pair(mk_pair(0, 0, 1'b0));
    send_pair(mk_pair(100, -100, 1'b0));
    send_pair(mk_pair(-32768, -32768, 1'b1));
    drain_results();
    write_delta(15'd1);
    send_pair(mk_pair(1, 0, 1'b0));
    send_pair(mk_pair(0, 2, 1'b0));
    send_pair(mk_pair(-1, 0, 1'b0));
    send_pair(mk_pair(12345, -321, 1'b1));

    phase_delta[0] = 15'd32767;
    phase_delta[1] = 15'd1;
    phase_delta[2] = 15'd0;
    phase_delta[3] = 15'd16384;
    phase_delta[4] = DeltaW'($urandom_range(1, 32767));
    phase_delta[5] = DeltaW'($urandom_range(1, 512));
    phase_delta[6] = DeltaRst;
    for (int ph = 0; ph < 7; ph++) begin
      drain_results();
      write_delta(phase_delta[ph]);
      sent = 0;
      while (sent < PhaseItems) begin
        r = $urandom_range(0, 19);
        if (r < 14) len = $urandom_range(1, 6);
        else if (r < 19) len = $urandom_range(7, 40);
        else len = $urandom_range(41, 120);
        run_set(len);
        sent += len;
      end
    end
    drain_results();

    $display("covered %0d pairs (%0d dropped past the count limit), %0d set means checked",
             sb.pairs_noted, sb.pairs_dropped, sb.sets_checked);
    $display("threshold written %0d times, zero and full scale included", sb.delta_writes);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
